### rtl/spmq_pkg.sv
// Package with constants, types and helper functions of the priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spmq_pkg;
  localparam int LEVELS = 4;
  localparam int DEPTH = 16;
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(LEVELS * DEPTH);
  localparam int TOT_W = $clog2(LEVELS * DEPTH + 1);
  localparam int AHEAD_W = TOT_W;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP = 3'd1;
  localparam logic [2:0] OP_PEEK = 3'd2;
  localparam logic [2:0] OP_COUNT = 3'd3;
  localparam logic [2:0] OP_POS = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  level;
    logic [15:0] flight_id;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] out_id;
    logic [3:0]  out_level;
    logic [6:0]  total_count;
    logic [4:0]  level_count;
    logic [5:0]  position;
  } rsp_t;

  // Request after classification by the front part.
  typedef struct packed {
    logic [2:0]  op;
    logic        lvl_ok;
    logic [LVL_W-1:0] q;
    logic [15:0] flight_id;
  } cmd_t;

  function automatic logic [6:0] sat_total(input logic [TOT_W-1:0] v);
    logic [TOT_W+7:0] w;
    begin
      w = {8'd0, v};
      sat_total = (w > (TOT_W+8)'(127)) ? 7'd127 : w[6:0];
    end
  endfunction

  function automatic logic [5:0] sat_pos(input logic [AHEAD_W-1:0] v);
    logic [AHEAD_W+7:0] w;
    begin
      w = {8'd0, v};
      sat_pos = (w > (AHEAD_W+8)'(63)) ? 6'd63 : w[5:0];
    end
  endfunction
endpackage
`default_nettype wire

### rtl/spmq_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module spmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH_W = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH_W)-1:0] waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH_W)-1:0] raddr,
  output logic      [WIDTH-1:0]           rdata
);
  logic [WIDTH-1:0] mem [DEPTH_W];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/spmq_front.sv
// Front part: takes requests, classifies the level and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module spmq_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire spmq_pkg::req_t  req,
  output logic                 busy,
  output logic                 cmd_valid,
  output spmq_pkg::cmd_t       cmd,
  input  wire logic            cmd_take,
  input  wire logic            back_idle
);
  import spmq_pkg::*;
  // Two-entry command queue.
  cmd_t q0, q1;
  logic [1:0] cnt;
  cmd_t c_in;
  logic acc;

  always_comb begin
    c_in.op = req.op;
    c_in.flight_id = req.flight_id;
    c_in.lvl_ok = (req.level >= 4'd1) && ({28'd0, req.level} <= LEVELS);
    c_in.q = LVL_W'(req.level - 4'd1);
  end

  // One request at a time in flight: the back part's state update must finish.
  assign busy = (cnt != 2'd0) || !back_idle;
  assign acc = start && !busy;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      if (acc && !(cmd_take && cnt != 2'd0)) cnt <= cnt + 2'd1;
      else if (!acc && cmd_take && cnt != 2'd0) cnt <= cnt - 2'd1;
    end
    if (cmd_take && cnt != 2'd0) begin
      q0 <= (cnt == 2'd2) ? q1 : c_in;
      if (acc && cnt == 2'd2) q1 <= c_in;
    end else if (acc) begin
      if (cnt == 2'd0) q0 <= c_in;
      else q1 <= c_in;
    end
  end
endmodule
`default_nettype wire

### rtl/spmq_back.sv
// Back part: executes commands against the level FIFOs held in one RAM.
`timescale 1ns / 1ps
`default_nettype none
module spmq_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire spmq_pkg::cmd_t  cmd,
  output logic                 cmd_take,
  output logic                 idle,
  output logic                 done,
  output spmq_pkg::rsp_t       result
);
  import spmq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state;
  logic [IDX_W-1:0]  head [LEVELS];
  logic [IDX_W-1:0]  tail [LEVELS];
  logic [FILL_W-1:0] fill [LEVELS];
  cmd_t cur;

  logic [LVL_W-1:0]   sq;
  logic [FILL_W-1:0]  sk;
  logic [IDX_W-1:0]   sidx;
  logic [AHEAD_W-1:0] ahead;
  logic               rd_pend;

  logic we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0] rdata;

  rsp_t result_next;
  logic done_next;

  spmq_ram #(.WIDTH(16), .DEPTH_W(LEVELS * DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(cmd.flight_id),
    .raddr(raddr), .rdata(rdata)
  );

  logic [TOT_W-1:0] total;
  logic             any;
  logic [LVL_W-1:0] first;
  always_comb begin
    total = '0;
    any = 1'b0;
    first = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      total = total + TOT_W'(fill[i]);
      if (fill[i] != '0) begin
        any = 1'b1;
        first = LVL_W'(i);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] l,
                                                input logic [IDX_W-1:0] i);
    addr_of = ADDR_W'(l * DEPTH + i);
  endfunction

  function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
    nxt = ({1'b0, i} + 1 >= DEPTH) ? '0 : IDX_W'(i + 1'b1);
  endfunction

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign idle = (state == S_IDLE) && !cmd_valid;
  assign we = cmd_take && cmd.op == OP_PUSH && cmd.lvl_ok && fill[cmd.q] < FILL_W'(DEPTH);
  assign waddr = addr_of(cmd.q, tail[cmd.q]);

  always_comb begin
    if (state == S_SCAN) raddr = addr_of(sq, sidx);
    else raddr = addr_of(first, head[first]);
  end

  logic hit_now;
  assign hit_now = rd_pend && rdata == cur.flight_id;

  logic last_level;
  assign last_level = ({1'b0, sq} == (LVL_W+1)'(LEVELS - 1));

  // Result fields and the strobe for the cycle after this edge.
  always_comb begin
    result_next = result;
    done_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        result_next = '0;
        case (cmd.op)
          OP_PUSH: begin
            result_next.ok = we;
            result_next.total_count = sat_total(total + TOT_W'(we));
            done_next = cmd_valid;
          end
          OP_POP, OP_PEEK: begin
            result_next.total_count = sat_total(total);
            done_next = cmd_valid && !any;
          end
          OP_COUNT: begin
            result_next.ok = cmd.lvl_ok;
            result_next.level_count = cmd.lvl_ok ? 5'(fill[cmd.q]) : 5'd0;
            result_next.total_count = sat_total(total);
            done_next = cmd_valid;
          end
          OP_POS: begin
            done_next = 1'b0;
          end
          default: begin
            result_next.total_count = sat_total(total);
            done_next = cmd_valid;
          end
        endcase
      end
      S_READ: begin
        result_next.ok = 1'b1;
        result_next.out_id = rdata;
        result_next.out_level = 4'(first) + 4'd1;
        if (cur.op == OP_POP) result_next.total_count = sat_total(total - 1'b1);
        else result_next.total_count = sat_total(total);
        done_next = 1'b1;
      end
      S_SCAN: begin
        if (hit_now) begin
          result_next.ok = 1'b1;
          result_next.total_count = sat_total(total);
          done_next = 1'b1;
        end else if (sk < fill[sq]) begin
          result_next.position = sat_pos(ahead + AHEAD_W'(sk));
        end else if (last_level) begin
          result_next.position = '0;
          result_next.total_count = sat_total(total);
          done_next = 1'b1;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      rd_pend <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      done <= done_next;
      result <= result_next;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            case (cmd.op)
              OP_PUSH: begin
                if (we) begin
                  tail[cmd.q] <= nxt(tail[cmd.q]);
                  fill[cmd.q] <= fill[cmd.q] + 1'b1;
                end
              end
              OP_POP, OP_PEEK: begin
                if (any) state <= S_READ;
              end
              OP_POS: begin
                sq <= '0;
                sk <= '0;
                sidx <= head[0];
                ahead <= '0;
                rd_pend <= 1'b0;
                state <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (cur.op == OP_POP) begin
            head[first] <= nxt(head[first]);
            fill[first] <= fill[first] - 1'b1;
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          // One stored entry read per cycle; the compare sees the previous read.
          if (hit_now) begin
            rd_pend <= 1'b0;
            state <= S_IDLE;
          end else if (sk < fill[sq]) begin
            rd_pend <= 1'b1;
            sk <= sk + 1'b1;
            sidx <= nxt(sidx);
          end else if (last_level) begin
            rd_pend <= 1'b0;
            state <= S_IDLE;
          end else begin
            rd_pend <= 1'b0;
            ahead <= ahead + AHEAD_W'(fill[sq]);
            sq <= sq + 1'b1;
            sk <= '0;
            sidx <= head[LVL_W'(sq + 1'b1)];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/strict_priority_multilevel_queue.sv
// Top level of the strict-priority multilevel queue.
// A request is taken when start is high and busy is low; its result appears for one
// cycle with done high and cannot be held off. Push, count, unused codes and a pop or
// peek on an empty queue are answered without a RAM read; a pop or peek that serves an
// entry also waits for one registered RAM read. A position query walks the stored
// entries one per cycle, most urgent level first, with an extra step for each level it
// passes. One request is in work at a time; busy drops in the cycle its result is
// presented.
`timescale 1ns / 1ps
`default_nettype none
module strict_priority_multilevel_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire spmq_pkg::req_t req,
  output logic                busy,
  output logic                done,
  output spmq_pkg::rsp_t      result
);
  import spmq_pkg::*;
  logic cmd_valid, cmd_take, back_idle;
  cmd_t cmd;

  spmq_front u_front (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take), .back_idle(back_idle)
  );

  spmq_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .idle(back_idle), .done(done), .result(result)
  );
endmodule
`default_nettype wire

### tb/spmq_checker.sv
// Checker that predicts queue responses from accepted requests and compares them.
`timescale 1ns / 1ps
module spmq_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  spmq_pkg::req_t  req,
  input  logic            done,
  input  spmq_pkg::rsp_t  result,
  output int              fail_count,
  output int              pending
);
  import spmq_pkg::*;

  logic [15:0] slot_id [LEVELS][DEPTH];
  int          front [LEVELS];
  int          fill [LEVELS];
  rsp_t        expected_rsp [$];

  assign pending = expected_rsp.size();

  // Applies one request to the shadow queues and returns the response it should give.
  function automatic rsp_t serve_request(input req_t r);
    rsp_t o;
    int   ahead;
    int   total;
    int   q;
    int   idx;
    bit   lvl_valid;
    o = '0;
    ahead = 0;
    total = 0;
    q = -1;
    lvl_valid = (r.level >= 1) && (r.level <= LEVELS);
    case (r.op)
      OP_PUSH: begin
        if (lvl_valid && fill[r.level-1] < DEPTH) begin
          idx = (front[r.level-1] + fill[r.level-1]) % DEPTH;
          slot_id[r.level-1][idx] = r.flight_id;
          fill[r.level-1]++;
          o.ok = 1'b1;
        end
      end
      OP_POP, OP_PEEK: begin
        for (int i = LEVELS - 1; i >= 0; i--)
          if (fill[i] != 0) q = i;
        if (q >= 0) begin
          o.ok = 1'b1;
          o.out_id = slot_id[q][front[q]];
          o.out_level = 4'(q + 1);
          if (r.op == OP_POP) begin
            front[q] = (front[q] + 1) % DEPTH;
            fill[q]--;
          end
        end
      end
      OP_COUNT: begin
        if (lvl_valid) begin
          o.ok = 1'b1;
          o.level_count = 5'(fill[r.level-1]);
        end
      end
      OP_POS: begin
        for (int i = 0; i < LEVELS && !o.ok; i++) begin
          for (int k = 0; k < fill[i] && !o.ok; k++) begin
            if (slot_id[i][(front[i] + k) % DEPTH] == r.flight_id) begin
              o.ok = 1'b1;
              o.position = (ahead + k > 63) ? 6'd63 : 6'(ahead + k);
            end
          end
          ahead += fill[i];
        end
      end
      default: ;
    endcase
    for (int i = 0; i < LEVELS; i++) total += fill[i];
    o.total_count = (total > 127) ? 7'd127 : 7'(total);
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      fail_count <= 0;
      expected_rsp.delete();
      for (int i = 0; i < LEVELS; i++) begin
        front[i] = 0;
        fill[i] = 0;
      end
    end else begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          if (fail_count < 10) $display("unexpected response %h", result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_rsp.pop_front();
          if (result !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: expected ok=%0d id=%h lvl=%0d tot=%0d lc=%0d pos=%0d",
                       want.ok, want.out_id, want.out_level, want.total_count,
                       want.level_count, want.position);
              $display("          got      ok=%0d id=%h lvl=%0d tot=%0d lc=%0d pos=%0d",
                       result.ok, result.out_id, result.out_level,
                       result.total_count, result.level_count, result.position);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_rsp.push_back(serve_request(req));
    end
  end
endmodule

### tb/tb_strict_priority_multilevel_queue.sv
// Top of the queue testbench: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_strict_priority_multilevel_queue;
  import spmq_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic  clk;
  logic  rst;
  logic  start;
  req_t  req;
  logic  busy;
  logic  done;
  rsp_t  result;
  int    fail_count;
  int    pending;
  int    idle_cycles;
  logic [15:0] recent_ids [$];

  strict_priority_multilevel_queue dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .result(result)
  );

  spmq_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Nothing accepted and no result for too long means the block hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb_strict_priority_multilevel_queue: FAIL");
      $finish;
    end
  end

  // Holds one request on the bus until it is accepted, after a random gap.
  // Start stays high after acceptance so that a request with no gap follows at once.
  task automatic send_request(input logic [2:0] op, input logic [3:0] lvl,
                              input logic [15:0] id, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= '{op: op, level: lvl, flight_id: id};
    do @(posedge clk); while (busy);
    if (op == OP_PUSH) begin
      recent_ids.push_back(id);
      if (recent_ids.size() > 32) void'(recent_ids.pop_front());
    end
  endtask

  task automatic random_request();
    int          pick;
    logic [2:0]  op;
    logic [3:0]  lvl;
    logic [15:0] id;
    pick = $urandom_range(0, 99);
    lvl = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, LEVELS));
    id = 16'($urandom);
    if (pick < 40) op = OP_PUSH;
    else if (pick < 62) op = OP_POP;
    else if (pick < 72) op = OP_PEEK;
    else if (pick < 82) op = OP_COUNT;
    else if (pick < 97) begin
      op = OP_POS;
      if (recent_ids.size() != 0 && $urandom_range(0, 3) != 0)
        id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    end else op = 3'($urandom_range(5, 7));
    send_request(op, lvl, id, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int burst;
    start = 1'b0;
    req = '0;
    rst = 1'b1;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue: pop, peek, position, two invalid counts, unused code; then pushes and queries.
    send_request(OP_POP, 4'd1, 16'h0000, 1'b0);
    send_request(OP_PEEK, 4'd1, 16'h0000, 1'b0);
    send_request(OP_POS, 4'd1, 16'hFFFF, 1'b0);
    send_request(OP_COUNT, 4'd0, 16'h0000, 1'b0);
    send_request(OP_COUNT, 4'd15, 16'h0000, 1'b0);
    send_request(3'd7, 4'd2, 16'hA5A5, 1'b0);
    send_request(OP_PUSH, 4'd0, 16'h1234, 1'b0);
    send_request(OP_PUSH, 4'd15, 16'h1234, 1'b0);
    send_request(OP_PUSH, 4'(LEVELS), 16'hFFFF, 1'b0);
    send_request(OP_PUSH, 4'd1, 16'h0000, 1'b0);
    send_request(OP_PUSH, 4'd2, 16'hFFFF, 1'b0);
    send_request(OP_POS, 4'd0, 16'hFFFF, 1'b0);
    send_request(OP_COUNT, 4'(LEVELS), 16'h0000, 1'b0);
    send_request(OP_PEEK, 4'd3, 16'h0000, 1'b0);
    // Fill level 3 past full to hit the reject.
    for (int i = 0; i <= DEPTH; i++) send_request(OP_PUSH, 4'd3, 16'(16'h5500 + i), 1'b1);
    send_request(OP_COUNT, 4'd3, 16'h0000, 1'b0);
    send_request(OP_POS, 4'd3, 16'h550F, 1'b0);
    send_request(3'd5, 4'd1, 16'h0000, 1'b0);
    send_request(3'd6, 4'd1, 16'h0000, 1'b0);
    start <= 1'b0;

    // Wait until every expected response has come back before going on.
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < 760; n++) begin
      random_request();
      // Occasionally send a burst of pops to exercise wrap and, if long enough, empty again.
      if ($urandom_range(0, 199) == 0) begin
        burst = $urandom_range(10, 70);
        repeat (burst) send_request(OP_POP, 4'd1, 16'h0000, 1'b1);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("tb_strict_priority_multilevel_queue: PASS");
    else $display("tb_strict_priority_multilevel_queue: FAIL");
    $finish;
  end
endmodule

### files.f
rtl/spmq_pkg.sv
rtl/spmq_ram.sv
rtl/spmq_front.sv
rtl/spmq_back.sv
rtl/strict_priority_multilevel_queue.sv
tb/spmq_checker.sv
tb/tb_strict_priority_multilevel_queue.sv
